[src/eam_density_embedding_spline_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the EAM density and embedding spline block.
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef EAM_DENSITY_EMBEDDING_SPLINE_MACROS_SVH
`define EAM_DENSITY_EMBEDDING_SPLINE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EDS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define EDS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/eds_pkg.sv]
// ----------------------------------------------------------------------------
// eds_pkg
// Types, constants and arithmetic helpers of the EAM spline evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eds_pkg;

    typedef logic signed [31:0] word_t;
    typedef logic [19:0] dist_t;

    // Item modes.
    localparam logic [1:0] MODE_EVAL  = 2'd0;
    localparam logic [1:0] MODE_KNOT  = 2'd1;
    localparam logic [1:0] MODE_DCOEF = 2'd2;
    localparam logic [1:0] MODE_ECOEF = 2'd3;

    // Register index of the cutoff register.
    localparam logic REG_CUTOFF = 1'b0;
    localparam dist_t CUTOFF_RESET = 20'd364249;

    // Distance thresholds in Q4.16.
    localparam dist_t SPLINE_START = 20'd132449;
    localparam dist_t TAIL_ORIGIN  = 20'd132448;
    localparam dist_t TAIL_FLOOR   = 20'd59014;

    // Q8.24 constants.
    localparam word_t TAIL_SLOPE     = 32'sd1308623;
    localparam word_t TAIL_OFFSET    = 32'sd1466329;
    localparam word_t EMB_THRESH     = 32'sd21808704;
    localparam word_t EMB_SLOPE      = 32'sd11959034;
    localparam word_t EMB_ORIGIN     = 32'sd21810381;
    localparam word_t NEG_EMB_OFFSET = -32'sd42807104;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KFIRST,
        ST_KWALK,
        ST_KLOAD,
        ST_COEF,
        ST_CUBIC,
        ST_EMB,
        ST_DONE
    } state_t;

    // Saturate a wide signed value to 32 bits.
    function automatic word_t sat_word(input logic signed [39:0] v);
        word_t r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q8.24 product, floored and saturated.
    function automatic word_t mul_q24(input word_t a, input word_t b);
        logic signed [63:0] prod;
        prod = a * b;
        return sat_word($signed(prod[63:24]));
    endfunction

    // Start of embedding row n: n / 10 in Q8.24, rounded up.
    function automatic word_t emb_base(input logic [3:0] n);
        word_t r;
        case (n)
            4'd1:    r = 32'sd1677722;
            4'd2:    r = 32'sd3355444;
            4'd3:    r = 32'sd5033165;
            4'd4:    r = 32'sd6710887;
            4'd5:    r = 32'sd8388608;
            4'd6:    r = 32'sd10066330;
            4'd7:    r = 32'sd11744052;
            4'd8:    r = 32'sd13421773;
            4'd9:    r = 32'sd15099495;
            4'd10:   r = 32'sd16777216;
            4'd11:   r = 32'sd18454938;
            4'd12:   r = 32'sd20132660;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[src/eds_if.sv]
// ----------------------------------------------------------------------------
// eds_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface eds_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [3:0]  row;
    logic [1:0]  coef_index;
    logic signed [31:0] table_word;
    logic [19:0] distance;

    modport source (output valid, mode, row, coef_index, table_word, distance,
                    input ready);
    modport sink (input valid, mode, row, coef_index, table_word, distance,
                  output ready);
endinterface

interface eds_result_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] density;
    logic signed [31:0] density_slope;
    logic signed [31:0] embed_energy;
    logic signed [31:0] embed_slope;

    modport source (output valid, density, density_slope, embed_energy, embed_slope,
                    input ready);
    modport sink (input valid, density, density_slope, embed_energy, embed_slope,
                  output ready);
endinterface

`default_nettype wire

[src/eds_cubic.sv]
// ----------------------------------------------------------------------------
// eds_cubic
// Cubic polynomial and slope on one shared Q8.24 multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eds_cubic (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  eds_pkg::word_t x,
    input  eds_pkg::word_t coef [4],
    output logic          done,
    output eds_pkg::word_t val,
    output eds_pkg::word_t slope
);

    logic [2:0] step_reg;
    eds_pkg::word_t x2_reg, x3_reg, m1_reg, m2_reg, m3_reg, s2_reg, s3_reg;
    eds_pkg::word_t op_a, op_b, prod;
    logic signed [39:0] val_sum, slope_sum;

    // Step counter runs while enabled and restarts otherwise.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
        end
        else
        begin
            step_reg <= en ? step_reg + 3'd1 : 3'd0;
        end
    end

    // Operand selection for the product of each step.
    always_comb
    begin
        case (step_reg)
            3'd0:    begin op_a = x;       op_b = x;      end
            3'd1:    begin op_a = x2_reg;  op_b = x;      end
            3'd2:    begin op_a = coef[1]; op_b = x;      end
            3'd3:    begin op_a = coef[2]; op_b = x2_reg; end
            3'd4:    begin op_a = coef[3]; op_b = x3_reg; end
            3'd5:    begin op_a = coef[2]; op_b = x;      end
            3'd6:    begin op_a = coef[3]; op_b = x2_reg; end
            default: begin op_a = '0;      op_b = '0;     end
        endcase
        prod = eds_pkg::mul_q24(op_a, op_b);
    end

    // Products are kept in their own registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (step_reg)
                3'd0:    x2_reg <= prod;
                3'd1:    x3_reg <= prod;
                3'd2:    m1_reg <= prod;
                3'd3:    m2_reg <= prod;
                3'd4:    m3_reg <= prod;
                3'd5:    s2_reg <= prod;
                3'd6:    s3_reg <= prod;
                default: ;
            endcase
        end
    end

    // Final sums in the last step.
    always_comb
    begin
        val_sum   = 40'(coef[0]) + 40'(m1_reg) + 40'(m2_reg) + 40'(m3_reg);
        slope_sum = 40'(coef[1]) + (40'(s2_reg) <<< 1) + (40'(s3_reg) <<< 1)
                    + 40'(s3_reg);
    end

    assign val   = eds_pkg::sat_word(val_sum);
    assign slope = eds_pkg::sat_word(slope_sum);
    assign done  = en && (step_reg == 3'd7);

endmodule

`default_nettype wire

[src/eam_density_embedding_spline.sv]
// ----------------------------------------------------------------------------
// eam_density_embedding_spline
// Loads spline tables and evaluates EAM electron density and embedding.
// ----------------------------------------------------------------------------
// Usage: items arrive on the item channel (valid/ready). Mode zero evaluates
// the distance; the other modes write one word of the knot table, the density
// coefficients or the embedding coefficients. Each item gives one result
// transaction on the result channel; load items return all zero fields.
// The cutoff radius is written through the APB port (register 0).
// Items are handled one at a time. A load item goes straight to the done state,
// whence its result is loaded into the output register. An evaluation on the
// linear density tail goes straight to the cubic unit; one that gives zero
// density at once goes straight to the embedding step. On the spline, a knot
// search walks the segments up from the start segment, or steps down one when
// the distance lies below the start knot; a search that runs off the table
// gives zero density. A density at or above the embedding threshold skips the
// coefficient fetch. Evaluation time is set by the single multiplier, which
// forms seven products per cubic, and by each table memory's one read port.
// The result sits in an output register: a stalled receiver holds it there,
// and the block still accepts and works on the next item, waiting only when
// that item's result is ready and the register is still full.
// Reset empties the output register, returns to idle and restores the cutoff;
// the tables keep no reset value and must be loaded before use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eam_density_embedding_spline #(
    parameter int KNOT_ROWS         = 15,
    parameter int EMBED_ROWS        = 13,
    parameter int SEGMENTS_PER_UNIT = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    eds_item_if.sink           item,
    eds_result_if.source       result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int KR_W = $clog2(KNOT_ROWS);
    localparam int ER_W = $clog2(EMBED_ROWS);
    localparam int DA_W = KR_W + 2;
    localparam int EA_W = ER_W + 2;
    localparam int LAST = KNOT_ROWS - 1;

    // Table memories.
    eds_pkg::dist_t knot_mem [KNOT_ROWS];
    eds_pkg::word_t dens_mem [KNOT_ROWS * 4];
    eds_pkg::word_t emb_mem  [EMBED_ROWS * 4];

    eds_pkg::state_t state_reg, state_next;
    eds_pkg::dist_t  cutoff_reg, dist_reg, kp_reg, kdata_reg;
    logic [KR_W-1:0] p_reg;
    logic [ER_W-1:0] erow_reg;
    logic [2:0]      cnt_reg;
    logic            phase_reg;
    eds_pkg::word_t  x_reg, ddata_reg, edata_reg;
    eds_pkg::word_t  coef_reg [4];
    eds_pkg::word_t  rho_reg, drho_reg, f_reg, df_reg;
    eds_pkg::word_t  out_rho_reg, out_drho_reg, out_f_reg, out_df_reg;
    logic            out_valid_reg, out_valid_next;

    logic            in_fire, out_load, cfg_write;
    logic [7:0]      row_ext;
    logic [6:0]      p0;
    logic            is_spline, spline_zero, is_tail, is_eval;
    logic            below, hit, walk_end, emb_tail;
    logic [1:0]      coef_idx;
    logic [20:0]     tail_diff, dens_diff;
    eds_pkg::word_t  tail_x, dens_x, emb_base_val;
    logic [29:0]     tenx;
    logic [5:0]      floor_row, erow_full;
    logic            knot_ren, coef_ren;
    logic [KR_W-1:0] knot_raddr;
    logic [DA_W-1:0] dens_raddr, dens_waddr;
    logic [EA_W-1:0] emb_raddr, emb_waddr;
    logic            cub_en, cub_done;
    eds_pkg::word_t  cub_val, cub_slope;

    assign in_fire  = item.valid && item.ready;
    assign out_load = (state_reg == eds_pkg::ST_DONE) && (!out_valid_reg || result.ready);
    assign row_ext  = {4'b0, item.row};
    assign is_eval  = (item.mode == eds_pkg::MODE_EVAL);

    // Classification of an arriving distance.
    always_comb
    begin
        p0          = 7'((item.distance[19:16] - 4'd2) * SEGMENTS_PER_UNIT);
        is_spline   = item.distance >= eds_pkg::SPLINE_START;
        spline_zero = (p0 >= 7'(LAST)) || (item.distance > cutoff_reg);
        is_tail     = item.distance > eds_pkg::TAIL_FLOOR;
        tail_diff   = {1'b0, item.distance} - {1'b0, eds_pkg::TAIL_ORIGIN};
        tail_x      = {{3{tail_diff[20]}}, tail_diff, 8'b0};
    end

    // Segment walk decisions.
    always_comb
    begin
        below     = (dist_reg < kdata_reg) && (p_reg != '0);
        hit       = (kp_reg <= dist_reg) && (dist_reg < kdata_reg);
        walk_end  = (({1'b0, p_reg} + 1'b1) == (KR_W + 1)'(LAST));
        dens_diff = {1'b0, dist_reg} - {1'b0, kp_reg};
        dens_x    = {{3{dens_diff[20]}}, dens_diff, 8'b0};
        coef_idx  = 2'(cnt_reg - 3'd1);
    end

    // Embedding row from the density.
    always_comb
    begin
        emb_tail  = rho_reg >= eds_pkg::EMB_THRESH;
        tenx      = ({5'b0, rho_reg[24:0]} << 3) + ({5'b0, rho_reg[24:0]} << 1);
        floor_row = (rho_reg > 32'sd0) ? tenx[29:24] : 6'd0;
        erow_full = (floor_row > 6'(EMBED_ROWS - 1)) ? 6'(EMBED_ROWS - 1) : floor_row;
        emb_base_val = eds_pkg::emb_base(erow_full[3:0]);
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            eds_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!is_eval)
                        state_next = eds_pkg::ST_DONE;
                    else if (is_spline)
                        state_next = spline_zero ? eds_pkg::ST_EMB : eds_pkg::ST_KFIRST;
                    else if (is_tail)
                        state_next = eds_pkg::ST_CUBIC;
                    else
                        state_next = eds_pkg::ST_EMB;
                end
            end
            eds_pkg::ST_KFIRST:
                state_next = below ? eds_pkg::ST_KLOAD : eds_pkg::ST_KWALK;
            eds_pkg::ST_KWALK:
            begin
                if (hit)
                    state_next = eds_pkg::ST_COEF;
                else if (walk_end)
                    state_next = eds_pkg::ST_EMB;
            end
            eds_pkg::ST_KLOAD:
                state_next = eds_pkg::ST_COEF;
            eds_pkg::ST_COEF:
                if (cnt_reg == 3'd4)
                    state_next = eds_pkg::ST_CUBIC;
            eds_pkg::ST_CUBIC:
                if (cub_done)
                    state_next = phase_reg ? eds_pkg::ST_DONE : eds_pkg::ST_EMB;
            eds_pkg::ST_EMB:
                state_next = emb_tail ? eds_pkg::ST_CUBIC : eds_pkg::ST_COEF;
            eds_pkg::ST_DONE:
                if (out_load)
                    state_next = eds_pkg::ST_IDLE;
            default:
                state_next = eds_pkg::ST_IDLE;
        endcase
    end

    // Control outputs: handshake, memory reads, cubic enable.
    always_comb
    begin
        item.ready = 1'b0;
        knot_ren   = 1'b0;
        knot_raddr = p_reg;
        coef_ren   = 1'b0;
        cub_en     = 1'b0;
        unique case (state_reg)
            eds_pkg::ST_IDLE:
            begin
                item.ready = 1'b1;
                knot_ren   = in_fire && is_eval && is_spline && !spline_zero;
                knot_raddr = p0[KR_W-1:0];
            end
            eds_pkg::ST_KFIRST:
            begin
                knot_ren   = 1'b1;
                knot_raddr = below ? KR_W'(p_reg - 1'b1) : KR_W'(p_reg + 1'b1);
            end
            eds_pkg::ST_KWALK:
            begin
                knot_ren   = !hit && !walk_end;
                knot_raddr = KR_W'(p_reg + 2'd2);
            end
            eds_pkg::ST_COEF:
                coef_ren = (cnt_reg != 3'd4);
            eds_pkg::ST_CUBIC:
                cub_en = 1'b1;
            default: ;
        endcase
    end

    assign dens_raddr = {p_reg, cnt_reg[1:0]};
    assign emb_raddr  = {erow_reg, cnt_reg[1:0]};
    assign dens_waddr = {row_ext[KR_W-1:0], item.coef_index};
    assign emb_waddr  = {row_ext[ER_W-1:0], item.coef_index};

    // Knot memory.
    always_ff @(posedge clk)
    begin
        if (in_fire && item.mode == eds_pkg::MODE_KNOT && {2'b0, item.row} < 6'(KNOT_ROWS))
            knot_mem[row_ext[KR_W-1:0]] <= item.table_word[19:0];
        if (knot_ren)
            kdata_reg <= knot_mem[knot_raddr];
    end

    // Density coefficient memory.
    always_ff @(posedge clk)
    begin
        if (in_fire && item.mode == eds_pkg::MODE_DCOEF && {2'b0, item.row} < 6'(KNOT_ROWS))
            dens_mem[dens_waddr] <= item.table_word;
        if (coef_ren && !phase_reg)
            ddata_reg <= dens_mem[dens_raddr];
    end

    // Embedding coefficient memory.
    always_ff @(posedge clk)
    begin
        if (in_fire && item.mode == eds_pkg::MODE_ECOEF && {2'b0, item.row} < 6'(EMBED_ROWS))
            emb_mem[emb_waddr] <= item.table_word;
        if (coef_ren && phase_reg)
            edata_reg <= emb_mem[emb_raddr];
    end

    // Shared cubic unit.
    eds_cubic u_cubic (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (cub_en),
        .x     (x_reg),
        .coef  (coef_reg),
        .done  (cub_done),
        .val   (cub_val),
        .slope (cub_slope)
    );

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            eds_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    dist_reg  <= item.distance;
                    p_reg     <= p0[KR_W-1:0];
                    phase_reg <= 1'b0;
                    rho_reg   <= '0;
                    drho_reg  <= '0;
                    f_reg     <= '0;
                    df_reg    <= '0;
                    coef_reg[0] <= eds_pkg::TAIL_OFFSET;
                    coef_reg[1] <= eds_pkg::TAIL_SLOPE;
                    coef_reg[2] <= '0;
                    coef_reg[3] <= '0;
                    x_reg       <= tail_x;
                end
            end
            eds_pkg::ST_KFIRST:
            begin
                if (below)
                    p_reg <= KR_W'(p_reg - 1'b1);
                else
                    kp_reg <= kdata_reg;
            end
            eds_pkg::ST_KWALK:
            begin
                if (!hit)
                begin
                    p_reg  <= KR_W'(p_reg + 1'b1);
                    kp_reg <= kdata_reg;
                end
            end
            eds_pkg::ST_KLOAD:
                kp_reg <= kdata_reg;
            eds_pkg::ST_COEF:
            begin
                if (cnt_reg == 3'd0 && !phase_reg)
                    x_reg <= dens_x;
                if (cnt_reg != 3'd0)
                    coef_reg[coef_idx] <= phase_reg ? edata_reg : ddata_reg;
            end
            eds_pkg::ST_CUBIC:
            begin
                if (cub_done && !phase_reg)
                begin
                    rho_reg  <= cub_val;
                    drho_reg <= cub_slope;
                end
                else if (cub_done)
                begin
                    f_reg  <= cub_val;
                    df_reg <= cub_slope;
                end
            end
            eds_pkg::ST_EMB:
            begin
                phase_reg <= 1'b1;
                if (emb_tail)
                begin
                    coef_reg[0] <= eds_pkg::NEG_EMB_OFFSET;
                    coef_reg[1] <= eds_pkg::EMB_SLOPE;
                    coef_reg[2] <= '0;
                    coef_reg[3] <= '0;
                    x_reg       <= rho_reg - eds_pkg::EMB_ORIGIN;
                end
                else
                begin
                    erow_reg <= erow_full[ER_W-1:0];
                    x_reg    <= rho_reg - emb_base_val;
                end
            end
            eds_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    out_rho_reg  <= rho_reg;
                    out_drho_reg <= drho_reg;
                    out_f_reg    <= f_reg;
                    out_df_reg   <= df_reg;
                end
            end
            default: ;
        endcase
    end

    // Output register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= eds_pkg::ST_IDLE;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
            cutoff_reg    <= eds_pkg::CUTOFF_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= (state_reg == eds_pkg::ST_COEF) ? cnt_reg + 3'd1 : 3'd0;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
                cutoff_reg <= pwdata[19:0];
        end
    end

    // Configuration port.
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == eds_pkg::REG_CUTOFF);
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == eds_pkg::REG_CUTOFF) ? {12'b0, cutoff_reg} : 32'b0;

    // Result channel.
    assign result.valid         = out_valid_reg;
    assign result.density       = out_rho_reg;
    assign result.density_slope = out_drho_reg;
    assign result.embed_energy  = out_f_reg;
    assign result.embed_slope   = out_df_reg;

endmodule

`default_nettype wire

[src/eds_checker.sv]
// ----------------------------------------------------------------------------
// eds_checker
// Port-level checks of the spline evaluator, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "eam_density_embedding_spline_macros.svh"

module eds_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_density,
    input logic [31:0] out_embed_energy
);

    // A result transaction stays offered until it is taken.
    `EDS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // A stalled result keeps its payload.
    `EDS_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_density) && $stable(out_embed_energy), "stalled result changed")

    // Ready drops after each accepted item.
    `EDS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item accepted back to back")

    // A result never appears in the cycle right after reset.
    `EDS_ASSERT_IMP(a_no_early_result, $rose(rst_n), !out_valid, "result present out of reset")

endmodule

bind eam_density_embedding_spline eds_checker u_eds_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (item.valid),
    .in_ready         (item.ready),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .out_density      (result.density),
    .out_embed_energy (result.embed_energy)
);

`default_nettype wire

[tb/tb_eam_density_embedding_spline.sv]
// ----------------------------------------------------------------------------
// tb_eam_density_embedding_spline
// Self-checking testbench for the EAM density and embedding spline block.
// The tables are loaded first. A set of directed items follows, and then
// long runs of random loads and evaluations under several cutoff settings.
// Both channels idle and stall at random. A built-in predictor computes
// every result, and the results are checked in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_eam_density_embedding_spline;

    import eds_pkg::*;

    localparam int KNOTS  = 15;
    localparam int EROWS  = 13;
    localparam int SEG_PU = 4;
    localparam longint ONE_Q24 = 64'sd16777216;

    typedef struct {
        word_t dens;
        word_t dslope;
        word_t emb;
        word_t eslope;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    eds_item_if   item_ch ();
    eds_result_if res_ch ();

    eam_density_embedding_spline dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch.sink),
        .result  (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the block's tables and cutoff register.
    logic [19:0] knot_mem [KNOTS];
    word_t dens_mem [KNOTS*4];
    word_t emb_mem [EROWS*4];
    logic [19:0] cutoff_shadow;

    outcome_t pending_q[$];
    int error_count;
    int evals_sent;
    int loads_sent;
    int checked_count;
    bit busy_sender;
    int hold_request;
    bit calm_phase;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Safety stop after a generous fixed time.
    initial
    begin
        #50ms;
        $display("tb_eam_density_embedding_spline: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Floored Q8.24 product, saturated.
    function automatic longint qmul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clip32(p >>> 24);
    endfunction

    function automatic void poly_eval(input longint c0, input longint c1,
                                      input longint c2, input longint c3,
                                      input longint x, output longint val,
                                      output longint slope);
        longint x2;
        longint x3;
        x2 = qmul(x, x);
        x3 = qmul(x2, x);
        val = clip32(c0 + qmul(c1, x) + qmul(c2, x2) + qmul(c3, x3));
        slope = clip32(c1 + 2 * qmul(c2, x) + 3 * qmul(c3, x2));
    endfunction

    function automatic void eval_density(input logic [19:0] r, output longint rho,
                                         output longint slope);
        int p;
        bit done;
        longint dx;
        rho = 0;
        slope = 0;
        done = 1'b0;
        if (r >= SPLINE_START)
        begin
            p = (int'(r >> 16) - 2) * SEG_PU;
            if (p >= KNOTS - 1)
            begin
                p = KNOTS - 1;
                done = 1'b1;
            end
            if (!done && r < knot_mem[p] && p > 0)
            begin
                p = p - 1;
                done = 1'b1;
            end
            if (r > cutoff_shadow)
            begin
                p = KNOTS - 1;
                done = 1'b1;
            end
            while (!done && p <= KNOTS - 2)
            begin
                if (knot_mem[p] <= r && r < knot_mem[p+1]) done = 1'b1;
                else p++;
            end
            if (p < KNOTS - 1)
            begin
                dx = (longint'(r) - longint'(knot_mem[p])) * 256;
                poly_eval(dens_mem[p*4], dens_mem[p*4+1], dens_mem[p*4+2],
                          dens_mem[p*4+3], dx, rho, slope);
            end
        end
        else if (r > TAIL_FLOOR)
        begin
            rho = clip32(qmul(TAIL_SLOPE, (longint'(r) - longint'(TAIL_ORIGIN)) * 256)
                         + TAIL_OFFSET);
            slope = TAIL_SLOPE;
        end
    endfunction

    function automatic void eval_embedding(input longint rho, output longint f,
                                           output longint fs);
        longint erow;
        longint base;
        longint dr;
        if (rho >= EMB_THRESH)
        begin
            f = clip32(qmul(EMB_SLOPE, rho - EMB_ORIGIN) + NEG_EMB_OFFSET);
            fs = EMB_SLOPE;
        end
        else
        begin
            erow = 0;
            if (rho > 0) erow = (rho * 10) / ONE_Q24;
            if (erow > EROWS - 1) erow = EROWS - 1;
            base = (erow * ONE_Q24 + 9) / 10;
            dr = clip32(rho - base);
            poly_eval(emb_mem[erow*4], emb_mem[erow*4+1], emb_mem[erow*4+2],
                      emb_mem[erow*4+3], dr, f, fs);
        end
    endfunction

    // Applies one accepted transaction to the shadow state; returns its result.
    function automatic outcome_t predict_item(input logic [1:0] mode, input logic [3:0] row,
                                              input logic [1:0] ci, input word_t w,
                                              input logic [19:0] dist_in);
        outcome_t o;
        longint rho, rs, f, fs;
        o = '{default: '0};
        case (mode)
            MODE_KNOT:  if (row < KNOTS) knot_mem[row] = w[19:0];
            MODE_DCOEF: if (row < KNOTS) dens_mem[row*4+ci] = w;
            MODE_ECOEF: if (row < EROWS) emb_mem[row*4+ci] = w;
            default:
            begin
                eval_density(dist_in, rho, rs);
                eval_embedding(rho, f, fs);
                o.dens = word_t'(rho);
                o.dslope = word_t'(rs);
                o.emb = word_t'(f);
                o.eslope = word_t'(fs);
            end
        endcase
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input word_t want, input word_t got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        error_count++;
    endtask

    function automatic int pick_gap();
        int k;
        if (calm_phase) return 0;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one item; called and returning at a falling edge.
    task automatic send_item(input logic [1:0] mode, input logic [3:0] row,
                             input logic [1:0] ci, input word_t w,
                             input logic [19:0] dist_in);
        int gap;
        item_ch.valid = 1'b1;
        item_ch.mode = mode;
        item_ch.row = row;
        item_ch.coef_index = ci;
        item_ch.table_word = w;
        item_ch.distance = dist_in;
        do @(posedge clk); while (!item_ch.ready);
        pending_q.push_back(predict_item(mode, row, ci, w, dist_in));
        if (mode == MODE_EVAL) evals_sent++;
        else loads_sent++;
        @(negedge clk);
        gap = busy_sender ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic end_burst();
        item_ch.valid = 1'b0;
        wait (pending_q.size() == 0);
        repeat (60) @(negedge clk);
    endtask

    // APB register write; the block is idle when this is called.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == 3'd0) cutoff_shadow = value[19:0];
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Result receiver with random stalls and an optional long hold-off.
    initial
    begin
        int stall_left;
        stall_left = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_request--;
                res_ch.ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready = 1'b0;
            end
            else if (calm_phase)
            begin
                res_ch.ready = 1'b1;
            end
            else
            begin
                if ($urandom_range(0, 99) < 4) stall_left = $urandom_range(10, 40);
                res_ch.ready = $urandom_range(0, 99) < 75;
            end
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_q.size() == 0)
            begin
                report_mismatch("unexpected result density", 32'sd0, res_ch.density);
            end
            else
            begin
                want = pending_q.pop_front();
                checked_count++;
                if (res_ch.density !== want.dens)
                    report_mismatch("density", want.dens, res_ch.density);
                if (res_ch.density_slope !== want.dslope)
                    report_mismatch("density_slope", want.dslope, res_ch.density_slope);
                if (res_ch.embed_energy !== want.emb)
                    report_mismatch("embed_energy", want.emb, res_ch.embed_energy);
                if (res_ch.embed_slope !== want.eslope)
                    report_mismatch("embed_slope", want.eslope, res_ch.embed_slope);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic word_t pick_coef(input logic [1:0] ci);
        int k;
        k = $urandom_range(0, 99);
        if (k < 10) return word_t'($urandom());
        if (ci == 2'd0) return word_t'($urandom_range(0, 25000000)) - 32'sd2000000;
        return word_t'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endfunction

    // Knots spaced a quarter apart from 2.0, with jitter or fully random.
    function automatic word_t pick_knot(input int r, input bit wild);
        word_t w;
        w = word_t'($urandom());
        if (wild) return w;
        w[19:0] = 20'd131072 + 20'(r * 16384) + 20'($urandom_range(0, 3000));
        return w;
    endfunction

    task automatic load_all(input bit wild_knots);
        for (int r = 0; r < KNOTS; r++)
            send_item(MODE_KNOT, 4'(r), 2'($urandom()), pick_knot(r, wild_knots),
                      20'($urandom()));
        for (int i = 0; i < KNOTS * 4; i++)
            send_item(MODE_DCOEF, 4'(i / 4), 2'(i % 4), pick_coef(2'(i % 4)), 20'($urandom()));
        for (int i = 0; i < EROWS * 4; i++)
            send_item(MODE_ECOEF, 4'(i / 4), 2'(i % 4), pick_coef(2'(i % 4)), 20'($urandom()));
    endtask

    function automatic logic [19:0] pick_distance();
        int k;
        int j;
        k = $urandom_range(0, 99);
        if (k < 40) return 20'($urandom_range(SPLINE_START, 20'(cutoff_shadow + 20'd4000)));
        if (k < 55) return 20'($urandom_range(TAIL_FLOOR, SPLINE_START));
        if (k < 62) return 20'($urandom_range(0, TAIL_FLOOR + 1));
        if (k < 80) return 20'($urandom());
        if (k < 90)
        begin
            j = $urandom_range(0, KNOTS - 1);
            return knot_mem[j] + 20'($urandom_range(0, 2)) - 20'd1;
        end
        return cutoff_shadow + 20'($urandom_range(0, 2)) - 20'd1;
    endfunction

    task automatic random_item();
        int k;
        logic [1:0] ci;
        k = $urandom_range(0, 99);
        ci = 2'($urandom());
        if (k < 72) send_item(MODE_EVAL, 4'($urandom()), ci, word_t'($urandom()),
                              pick_distance());
        else if (k < 80) send_item(MODE_KNOT, 4'($urandom()), ci,
                                   pick_knot($urandom_range(0, KNOTS - 1), k < 75),
                                   20'($urandom()));
        else if (k < 90) send_item(MODE_DCOEF, 4'($urandom()), ci, pick_coef(ci),
                                   20'($urandom()));
        else send_item(MODE_ECOEF, 4'($urandom()), ci, pick_coef(ci), 20'($urandom()));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_table_load();
        load_all(1'b0);
        end_burst();
    endtask

    task automatic test_directed();
        // Distance extremes, tail edges, spline start and cutoff edges.
        send_item(MODE_EVAL, 4'd0, 2'd0, 32'sd0, 20'd0);
        send_item(MODE_EVAL, 4'd0, 2'd0, 32'sd0, TAIL_FLOOR);
        send_item(MODE_EVAL, 4'd0, 2'd0, 32'sd0, TAIL_FLOOR + 20'd1);
        send_item(MODE_EVAL, 4'd0, 2'd0, 32'sd0, TAIL_ORIGIN);
        send_item(MODE_EVAL, 4'd0, 2'd0, 32'sd0, SPLINE_START);
        send_item(MODE_EVAL, 4'd0, 2'd0, 32'sd0, cutoff_shadow);
        send_item(MODE_EVAL, 4'd0, 2'd0, 32'sd0, cutoff_shadow + 20'd1);
        send_item(MODE_EVAL, 4'd0, 2'd0, 32'sd0, 20'hFFFFF);
        // Start segment 12, near the end of the table.
        send_item(MODE_EVAL, 4'd0, 2'd0, 32'sd0, 20'h50000);
        // Distance just below the knot of its start segment.
        send_item(MODE_EVAL, 4'd0, 2'd0, 32'sd0, 20'h30000);
        send_item(MODE_EVAL, 4'd0, 2'd0, 32'sd0, knot_mem[4] - 20'd1);
        // Load rows past the table depth are ignored.
        send_item(MODE_KNOT, 4'd15, 2'd3, 32'sh7fffffff, 20'd0);
        send_item(MODE_DCOEF, 4'd15, 2'd3, -32'sh80000000, 20'd0);
        send_item(MODE_ECOEF, 4'd13, 2'd1, 32'sh7fffffff, 20'd0);
        send_item(MODE_ECOEF, 4'd15, 2'd2, -32'sd1, 20'd0);
        // Large density constant drives the embedding above its threshold.
        send_item(MODE_DCOEF, 4'd2, 2'd0, 32'sd30000000, 20'd0);
        send_item(MODE_EVAL, 4'd0, 2'd0, 32'sd0, knot_mem[2]);
        send_item(MODE_DCOEF, 4'd2, 2'd0, EMB_THRESH, 20'd0);
        send_item(MODE_EVAL, 4'd0, 2'd0, 32'sd0, knot_mem[2]);
        // Saturating coefficients, then negative density.
        send_item(MODE_DCOEF, 4'd3, 2'd3, 32'sh7fffffff, 20'hFFFFF);
        send_item(MODE_EVAL, 4'd0, 2'd0, 32'sd0, knot_mem[4] - 20'd1);
        send_item(MODE_DCOEF, 4'd2, 2'd0, -32'sh80000000, 20'd0);
        send_item(MODE_EVAL, 4'd0, 2'd0, 32'sd0, knot_mem[2]);
        end_burst();
    endtask

    task automatic test_cutoff_settings();
        logic [31:0] setting [5];
        setting[0] = 32'd0;
        setting[1] = 32'h000FFFFF;
        setting[2] = 32'd250000;
        setting[3] = 32'hFFFFFFFF;
        setting[4] = {12'd0, CUTOFF_RESET};
        // A write to the unused register index must change nothing.
        write_reg(3'd4, 32'd0);
        for (int s = 0; s < 5; s++)
        begin
            write_reg(3'd0, setting[s]);
            repeat (60) random_item();
            end_burst();
        end
    endtask

    task automatic test_backpressure();
        busy_sender = 1'b1;
        hold_request = 400;
        repeat (30) send_item(MODE_EVAL, 4'd0, 2'd0, 32'sd0, pick_distance());
        busy_sender = 1'b0;
        end_burst();
    endtask

    task automatic test_random_mix();
        for (int n = 0; n < 800; n++)
        begin
            if (n % 200 == 0) calm_phase = $urandom_range(0, 2) == 0;
            if (n == 400)
            begin
                // Rewrite every table with unordered knots and new settings.
                end_burst();
                write_reg(3'd0, $urandom());
                load_all(1'b1);
            end
            random_item();
        end
        calm_phase = 1'b0;
        end_burst();
    endtask

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_ch.valid = 1'b0;
        item_ch.mode = MODE_EVAL;
        item_ch.row = '0;
        item_ch.coef_index = '0;
        item_ch.table_word = '0;
        item_ch.distance = '0;
        error_count = 0;
        evals_sent = 0;
        loads_sent = 0;
        checked_count = 0;
        busy_sender = 1'b0;
        hold_request = 0;
        calm_phase = 1'b0;
        cutoff_shadow = CUTOFF_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (5) @(negedge clk);

        test_table_load();
        test_directed();
        test_cutoff_settings();
        test_backpressure();
        test_random_mix();

        $display("Covered %0d evaluations and %0d table loads; %0d results compared.",
                 evals_sent, loads_sent, checked_count);
        $display("Cutoff swept from 0 to full scale, with a long result hold-off.");
        if (error_count == 0)
            $display("tb_eam_density_embedding_spline: done, clean");
        else
            $display("tb_eam_density_embedding_spline: done, errors");
        $finish;
    end

endmodule
